// ----- src/waypoint_velocity_steering_unit_defines.svh -----
// waypoint_velocity_steering_unit_defines.svh
// Assertion macros for the waypoint steering unit. No dependencies.
// With SYNTHESIS defined the macros expand to nothing.
`ifndef WAYPOINT_VELOCITY_STEERING_UNIT_DEFINES_SVH
`define WAYPOINT_VELOCITY_STEERING_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while reset is released
`define WVS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wvs assertion failed");
// Checked at every edge, reset included
`define WVS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("wvs assertion failed");
`else
`define WVS_ASSERT(label, clk, rst_n, prop)
`define WVS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- src/wvs_pkg.sv -----
// wvs_pkg.sv
// Shared constants, codes and types of the waypoint steering unit.
// No dependencies; used by the interfaces and the top level.
package wvs_pkg;

    // Waypoint table
    localparam int MAX_WAYPOINTS = 16;
    localparam int WP_AW         = $clog2(MAX_WAYPOINTS);

    // Beat field widths
    localparam int COORD_W = 24;
    localparam int SLOT_W  = 4;
    localparam int VEL_W   = 17;
    localparam int PI_W    = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SPD_W      = 16;
    localparam int TOL_W      = 16;

    // Datapath widths
    localparam int DIFF_W     = COORD_W + 1;        // waypoint minus position
    localparam int SQ_W       = 2 * DIFF_W - 1;     // |d|^2 <= 2^48
    localparam int D2_W       = SQ_W + 1;           // dx^2 + dy^2
    localparam int ROOT_W     = D2_W / 2;           // floor(sqrt(d2))
    localparam int NUM_W      = SPD_W + DIFF_W;     // speed * |d|
    localparam int TOL2_W     = 2 * TOL_W;
    localparam int SQRT_STEPS = D2_W / 2;
    localparam int DIV_STEPS  = SPD_W;
    localparam int CNT_W      = 5;

    // Reset values of the registers
    localparam logic [SPD_W-1:0] SPEED_RST = SPD_W'(1188);  // 1.16 m/s
    localparam logic [TOL_W-1:0] TOL_RST   = TOL_W'(307);   // 0.3 m
    localparam logic [PI_W-1:0]  LEN_RST   = PI_W'(5);

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_POS  = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED = 2'd0,
        CFG_TOL   = 2'd1,
        CFG_LEN   = 2'd2
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MULT,
        S_SUM,
        S_SQRT,
        S_DIV,
        S_RESULT
    } t_state;

endpackage

// ----- src/wvs_in_if.sv -----
// wvs_in_if.sv
// Input channel: waypoint load and position sample beats.
// Depends on wvs_pkg for field widths.
interface wvs_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [wvs_pkg::SLOT_W-1:0]          slot;
    logic signed [wvs_pkg::COORD_W-1:0]  coord_x;
    logic signed [wvs_pkg::COORD_W-1:0]  coord_y;

    modport source (output valid, kind, slot, coord_x, coord_y, input ready);
    modport sink   (input valid, kind, slot, coord_x, coord_y, output ready);
endinterface

// ----- src/wvs_out_if.sv -----
// wvs_out_if.sv
// Output channel: velocity command beats.
// Depends on wvs_pkg for field widths.
interface wvs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [wvs_pkg::VEL_W-1:0]  vel_x;
    logic signed [wvs_pkg::VEL_W-1:0]  vel_y;
    logic                              route_done;
    logic [wvs_pkg::PI_W-1:0]          target_slot;

    modport source (output valid, vel_x, vel_y, route_done, target_slot, input ready);
    modport sink   (input valid, vel_x, vel_y, route_done, target_slot, output ready);
endinterface

// ----- src/waypoint_velocity_steering_unit.sv -----
// waypoint_velocity_steering_unit.sv
// Waypoint follower: waypoint table RAM, distance, square root, divider.
// Depends on wvs_pkg, wvs_in_if, wvs_out_if and the assertion macro header.
//
//  channel  | dir | beat contents
//  ---------+-----+------------------------------------------------
//  i_in     | in  | kind, slot, coord_x, coord_y
//  o_out    | out | vel_x, vel_y, route_done, target_slot
//  i_cfg_*  | in  | write enable, register index, 16-bit data
//
// A load or a dropped position beat is taken in the idle state alone. A steering beat
// runs read, difference, multiply, sum, a 25-step square root and a 16-step divider
// one after another, with read to sum run again after an advance; a stop beat and a
// beat at zero distance skip the square root and divider. One beat is in work at a time.
// The result waits in an output register, so a stalled sink holds only the final state.
// Reset is synchronous; the waypoint RAM is not cleared.
`include "waypoint_velocity_steering_unit_defines.svh"

module waypoint_velocity_steering_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    wvs_in_if.sink                          i_in,
    wvs_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [wvs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wvs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wvs_pkg::*;

    localparam logic [D2_W-1:0] SQRT_TOP = D2_W'(1) << (2 * (SQRT_STEPS - 1));

    // Control
    t_state              r_state, n_state;
    logic [PI_W-1:0]     r_prog, n_prog;
    logic [SPD_W-1:0]    r_speed;
    logic [TOL_W-1:0]    r_tol;
    logic [PI_W-1:0]     r_len;
    logic                r_second;
    logic [CNT_W-1:0]    r_cnt;

    // Waypoint RAM, x in the upper half
    logic [2*COORD_W-1:0] r_wp_mem [MAX_WAYPOINTS];
    logic [2*COORD_W-1:0] r_wp_rd;
    logic                 wr_en, rd_en;
    logic [WP_AW-1:0]     rd_addr;

    // Datapath
    logic signed [COORD_W-1:0] r_px, r_py;
    logic [DIFF_W-1:0]   r_mag_x, r_mag_y;
    logic                r_neg_x, r_neg_y;
    logic [SQ_W-1:0]     r_sq_x, r_sq_y;
    logic [TOL2_W-1:0]   r_tol2;
    logic [NUM_W-1:0]    r_num_x, r_num_y;
    logic [D2_W-1:0]     r_rem, r_root, r_sq_bit;
    logic [NUM_W-1:0]    r_dv;
    logic [SPD_W-1:0]    r_q_x, r_q_y;
    logic                r_done;

    // Output register
    logic                      r_out_valid;
    logic signed [VEL_W-1:0]   r_out_vx, r_out_vy;
    logic                      r_out_done;
    logic [PI_W-1:0]           r_out_slot;

    logic                      in_acc, in_ready, out_load;
    logic [PI_W-1:0]           eff_len, prog_inc;
    logic signed [COORD_W-1:0] wx, wy;
    logic signed [DIFF_W-1:0]  diff_x, diff_y;
    logic [DIFF_W-1:0]         mag_x, mag_y;
    logic [D2_W-1:0]           d2, sq_trial, rem_next, root_next;
    logic                      d2_lt, advance, route_end, sq_ge, ge_x, ge_y;
    logic [SPD_W-1:0]          sat_x, sat_y;
    logic signed [VEL_W-1:0]   vel_x, vel_y;

    // Common terms
    assign in_acc    = i_in.valid && in_ready;
    assign eff_len   = (r_len > PI_W'(MAX_WAYPOINTS)) ? PI_W'(MAX_WAYPOINTS) : r_len;
    assign prog_inc  = r_prog + PI_W'(1);
    assign d2        = D2_W'(r_sq_x) + D2_W'(r_sq_y);
    assign d2_lt     = d2 < D2_W'(r_tol2);
    assign advance   = !r_second && d2_lt;
    assign route_end = prog_inc >= eff_len;

    // Differences toward the target waypoint
    assign wx     = r_wp_rd[2*COORD_W-1:COORD_W];
    assign wy     = r_wp_rd[COORD_W-1:0];
    assign diff_x = DIFF_W'(wx) - DIFF_W'(r_px);
    assign diff_y = DIFF_W'(wy) - DIFF_W'(r_py);
    assign mag_x  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
    assign mag_y  = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);

    // Square root step: root and trial bit never overlap
    assign sq_trial  = r_root | r_sq_bit;
    assign sq_ge     = r_rem >= sq_trial;
    assign rem_next  = sq_ge ? (r_rem - sq_trial) : r_rem;
    assign root_next = sq_ge ? ((r_root >> 1) | r_sq_bit) : (r_root >> 1);

    // Divider lanes share the shifted divisor
    assign ge_x = r_num_x >= r_dv;
    assign ge_y = r_num_y >= r_dv;

    // Result shaping: clamp to speed, apply sign
    assign sat_x = (r_q_x > r_speed) ? r_speed : r_q_x;
    assign sat_y = (r_q_y > r_speed) ? r_speed : r_q_y;
    assign vel_x = r_neg_x ? -VEL_W'(sat_x) : VEL_W'(sat_x);
    assign vel_y = r_neg_y ? -VEL_W'(sat_y) : VEL_W'(sat_y);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.kind == KIND_POS && r_prog < eff_len) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: n_state = S_MULT;
            S_MULT: n_state = S_SUM;
            S_SUM: begin
                if (advance) begin
                    n_state = route_end ? S_RESULT : S_DIFF;
                end else if (d2 == '0) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_ready = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = r_prog[WP_AW-1:0];
        out_load = 1'b0;
        n_prog   = r_prog;
        case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_acc && i_in.kind == KIND_LOAD) begin
                    wr_en  = int'(i_in.slot) < MAX_WAYPOINTS;
                    n_prog = '0;
                end else if (in_acc) begin
                    rd_en = 1'b1;
                end
            end
            S_SUM: begin
                if (advance) begin
                    n_prog  = prog_inc;
                    rd_en   = !route_end;
                    rd_addr = prog_inc[WP_AW-1:0];
                end
            end
            S_RESULT: out_load = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prog  <= '0;
            r_speed <= SPEED_RST;
            r_tol   <= TOL_RST;
            r_len   <= LEN_RST;
        end else begin
            r_state <= n_state;
            r_prog  <= n_prog;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SPEED: r_speed <= i_cfg_data[SPD_W-1:0];
                    CFG_TOL:   r_tol   <= i_cfg_data[TOL_W-1:0];
                    CFG_LEN:   r_len   <= i_cfg_data[PI_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Waypoint RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wp_mem[WP_AW'(i_in.slot)] <= {i_in.coord_x, i_in.coord_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_wp_rd <= r_wp_mem[rd_addr];
        end
    end

    // Datapath, one step per state
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_px     <= i_in.coord_x;
                    r_py     <= i_in.coord_y;
                    r_second <= 1'b0;
                end
            end
            S_DIFF: begin
                r_mag_x <= mag_x;
                r_mag_y <= mag_y;
                r_neg_x <= diff_x[DIFF_W-1];
                r_neg_y <= diff_y[DIFF_W-1];
            end
            S_MULT: begin
                r_sq_x  <= SQ_W'(SQ_W'(r_mag_x) * SQ_W'(r_mag_x));
                r_sq_y  <= SQ_W'(SQ_W'(r_mag_y) * SQ_W'(r_mag_y));
                r_num_x <= NUM_W'(NUM_W'(r_speed) * NUM_W'(r_mag_x));
                r_num_y <= NUM_W'(NUM_W'(r_speed) * NUM_W'(r_mag_y));
                r_tol2  <= TOL2_W'(TOL2_W'(r_tol) * TOL2_W'(r_tol));
            end
            S_SUM: begin
                if (advance) begin
                    // stop beat if the route is finished, else steer to the next waypoint
                    r_second <= 1'b1;
                    r_q_x    <= '0;
                    r_q_y    <= '0;
                    r_neg_x  <= 1'b0;
                    r_neg_y  <= 1'b0;
                    r_done   <= 1'b1;
                end else if (d2 == '0) begin
                    // on the waypoint: head along +x
                    r_q_x   <= r_speed;
                    r_q_y   <= '0;
                    r_neg_x <= 1'b0;
                    r_neg_y <= 1'b0;
                    r_done  <= 1'b0;
                end else begin
                    r_rem    <= d2;
                    r_root   <= '0;
                    r_sq_bit <= SQRT_TOP;
                    r_cnt    <= CNT_W'(SQRT_STEPS - 1);
                    r_done   <= 1'b0;
                end
            end
            S_SQRT: begin
                r_rem    <= rem_next;
                r_root   <= root_next;
                r_sq_bit <= r_sq_bit >> 2;
                if (r_cnt == '0) begin
                    r_dv  <= NUM_W'(root_next[ROOT_W-1:0]) << (DIV_STEPS - 1);
                    r_cnt <= CNT_W'(DIV_STEPS - 1);
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            S_DIV: begin
                // quotient fits SPD_W bits since |d| <= dist
                r_num_x <= ge_x ? (r_num_x - r_dv) : r_num_x;
                r_num_y <= ge_y ? (r_num_y - r_dv) : r_num_y;
                r_q_x   <= {r_q_x[SPD_W-2:0], ge_x};
                r_q_y   <= {r_q_y[SPD_W-2:0], ge_y};
                r_dv    <= r_dv >> 1;
                r_cnt   <= r_cnt - CNT_W'(1);
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_vx   <= vel_x;
            r_out_vy   <= vel_y;
            r_out_done <= r_done;
            r_out_slot <= r_prog;
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.vel_x       = r_out_vx;
    assign o_out.vel_y       = r_out_vy;
    assign o_out.route_done  = r_out_done;
    assign o_out.target_slot = r_out_slot;

    // Checks
    `WVS_ASSERT(a_load_restarts, i_clk, i_rst_n, (in_acc && i_in.kind == KIND_LOAD) |=> (r_prog == '0))
    `WVS_ASSERT(a_done_drops, i_clk, i_rst_n, (in_acc && i_in.kind == KIND_POS && r_prog >= eff_len) |=> (r_state == S_IDLE))
    `WVS_ASSERT(a_stop_zero, i_clk, i_rst_n, (r_out_valid && r_out_done) |-> (r_out_vx == '0 && r_out_vy == '0))
    `WVS_ASSERT(a_div_nonzero, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_dv != '0))
    `WVS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!r_out_valid && r_state == S_IDLE))

endmodule
